// File: hw/rtl/sorted_insert_priority_queue_top_macros.svh
// assertion macros used by the priority queue top module
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SIQ_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication
`define SIQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define SIQ_ASSERT_NOW(label, clk, rst_n, cond, prop, msg)
`define SIQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// File: hw/rtl/siq_pkg.sv
// shared types and codes of the sorted insert priority queue
package siq_pkg;

    // command codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/siq_cell.sv
// one slot of the ordered chain: compare, insert or shift by one
module siq_cell #(
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 2
) (
    input  logic                     clk,
    input  siq_pkg::cell_ctrl_t      ctrl,
    input  logic                     occupied,
    input  logic                     ins_left,
    input  logic [TAG_BITS-1:0]      left_tag,
    input  logic [PRIORITY_BITS-1:0] left_pri,
    input  logic [TAG_BITS-1:0]      right_tag,
    input  logic [PRIORITY_BITS-1:0] right_pri,
    input  logic [TAG_BITS-1:0]      new_tag,
    input  logic [PRIORITY_BITS-1:0] new_pri,
    output logic                     ins,
    output logic [TAG_BITS-1:0]      tag,
    output logic [PRIORITY_BITS-1:0] pri
);

    logic [TAG_BITS-1:0]      tag_reg;
    logic [TAG_BITS-1:0]      tag_next;
    logic [PRIORITY_BITS-1:0] pri_reg;
    logic [PRIORITY_BITS-1:0] pri_next;

    // new item goes at or before this slot
    assign ins = !occupied || (new_pri < pri_reg);

    // slot update: take left neighbour, new item, right neighbour or hold
    always_comb
    begin
        tag_next = tag_reg;
        pri_next = pri_reg;
        if (ctrl.enq)
        begin
            if (ins_left)
            begin
                tag_next = left_tag;
                pri_next = left_pri;
            end
            else if (ins)
            begin
                tag_next = new_tag;
                pri_next = new_pri;
            end
        end
        else if (ctrl.deq)
        begin
            tag_next = right_tag;
            pri_next = right_pri;
        end
    end

    // slot storage, content undefined until written
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        pri_reg <= pri_next;
    end

    assign tag = tag_reg;
    assign pri = pri_reg;

endmodule

// File: hw/rtl/sorted_insert_priority_queue_top.sv
// Sorted insert priority queue built as a chain of compare-and-shift cells.
//
// Input channel (in_valid / in_stall): command 0 enqueues item_tag with
// item_priority, command 1 dequeues the head. Lower priority numbers are
// served first; equal priorities leave in arrival order.
// Output channel (out_valid / out_stall): one result beat per input beat with
// status (done, full, empty), the removed head's tag and priority on a good
// dequeue (zero otherwise) and the entry count after the command.
// Every cell compares the new priority with its own and either holds, takes
// the new item, or takes a neighbour's entry, so the whole chain updates at
// the edge that takes the command; the result beat follows in the next cycle.
// One beat per cycle unless stalled, limited by the single output register.
// While out_stall is high and a result is held, in_stall is raised and no
// command is taken; the held result does not change.
// Reset clears the entry count and the output valid; slot contents are
// undefined until written and are never read beyond the entry count.
`include "sorted_insert_priority_queue_top_macros.svh"
module sorted_insert_priority_queue_top #(
    parameter int DEPTH         = 16,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 2,
    localparam int CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     command,
    input  logic [TAG_BITS-1:0]      item_tag,
    input  logic [PRIORITY_BITS-1:0] item_priority,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [TAG_BITS-1:0]      out_tag,
    output logic [PRIORITY_BITS-1:0] out_priority,
    output logic [CNT_W-1:0]         entry_count
);

    logic                     accept;
    logic                     full;
    logic                     empty;
    siq_pkg::cell_ctrl_t      ctrl;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [TAG_BITS-1:0]      out_tag_reg;
    logic [TAG_BITS-1:0]      out_tag_next;
    logic [PRIORITY_BITS-1:0] out_pri_reg;
    logic [PRIORITY_BITS-1:0] out_pri_next;
    logic [CNT_W-1:0]         out_cnt_reg;

    logic [DEPTH-1:0]         occ;
    logic [DEPTH-1:0]         ins;
    logic [TAG_BITS-1:0]      tag_q [DEPTH];
    logic [PRIORITY_BITS-1:0] pri_q [DEPTH];

    // handshake: take a beat unless a held result is stalled
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // control broadcast to the chain
    assign ctrl.enq = accept && (command == siq_pkg::CMD_ENQUEUE) && !full;
    assign ctrl.deq = accept && (command == siq_pkg::CMD_DEQUEUE) && !empty;

    // chain of slots
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                     ins_left_w;
        logic [TAG_BITS-1:0]      left_tag_w;
        logic [PRIORITY_BITS-1:0] left_pri_w;
        logic [TAG_BITS-1:0]      right_tag_w;
        logic [PRIORITY_BITS-1:0] right_pri_w;

        assign occ[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign ins_left_w = 1'b0;
            assign left_tag_w = item_tag;
            assign left_pri_w = item_priority;
        end
        else
        begin : g_body
            assign ins_left_w = ins[i-1];
            assign left_tag_w = tag_q[i-1];
            assign left_pri_w = pri_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_tag_w = tag_q[i];
            assign right_pri_w = pri_q[i];
        end
        else
        begin : g_inner
            assign right_tag_w = tag_q[i+1];
            assign right_pri_w = pri_q[i+1];
        end

        siq_cell #(
            .TAG_BITS      (TAG_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occ[i]),
            .ins_left  (ins_left_w),
            .left_tag  (left_tag_w),
            .left_pri  (left_pri_w),
            .right_tag (right_tag_w),
            .right_pri (right_pri_w),
            .new_tag   (item_tag),
            .new_pri   (item_priority),
            .ins       (ins[i]),
            .tag       (tag_q[i]),
            .pri       (pri_q[i])
        );
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // result of the accepted beat
    always_comb
    begin
        out_tag_next = '0;
        out_pri_next = '0;
        if (command == siq_pkg::CMD_ENQUEUE)
        begin
            status_next = full ? siq_pkg::ST_FULL : siq_pkg::ST_DONE;
        end
        else
        begin
            status_next = empty ? siq_pkg::ST_EMPTY : siq_pkg::ST_DONE;
            if (!empty)
            begin
                out_tag_next = tag_q[0];
                out_pri_next = pri_q[0];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            out_tag_reg <= out_tag_next;
            out_pri_reg <= out_pri_next;
            out_cnt_reg <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_pri_reg;
    assign entry_count  = out_cnt_reg;

    // checks
    `SIQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH),
        "entry count beyond depth")
    `SIQ_ASSERT_NEXT(a_full_reject, clk, rst_n,
        accept && (command == siq_pkg::CMD_ENQUEUE) && full,
        (status_reg == siq_pkg::ST_FULL) && $stable(count_reg),
        "full enqueue not rejected")
    `SIQ_ASSERT_NEXT(a_head_out, clk, rst_n, ctrl.deq,
        (out_tag_reg == $past(tag_q[0])) && (out_pri_reg == $past(pri_q[0])),
        "dequeue did not return head")
    `SIQ_ASSERT_NEXT(a_result_valid, clk, rst_n, accept,
        out_valid_reg && (out_cnt_reg == count_reg),
        "accepted beat without matching result")

endmodule

// File: test/sorted_insert_priority_queue_top_tb.sv
// self-checking testbench for the sorted insert priority queue
`timescale 1ns / 1ps

module sorted_insert_priority_queue_top_tb;

    localparam int DEPTH         = 16;
    localparam int TAG_BITS      = 16;
    localparam int PRIORITY_BITS = 2;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int IDLE_PCT      = 29;
    localparam int CALM_FIRST    = 150;
    localparam int CALM_LAST     = 260;
    localparam int RANDOM_CMDS   = 400;
    localparam int CYCLE_LIMIT   = 40000;

    typedef struct {
        logic                     cmd;
        logic [TAG_BITS-1:0]      tag;
        logic [PRIORITY_BITS-1:0] prio;
        bit                       wait_drain;
    } queue_cmd_t;

    typedef struct {
        logic [1:0]               status;
        logic [TAG_BITS-1:0]      tag;
        logic [PRIORITY_BITS-1:0] prio;
        logic [CNT_W-1:0]         count;
    } queue_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     command = siq_pkg::CMD_ENQUEUE;
    logic [TAG_BITS-1:0]      item_tag = '0;
    logic [PRIORITY_BITS-1:0] item_priority = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic [TAG_BITS-1:0]      out_tag;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [CNT_W-1:0]         entry_count;

    // stimulus backlog and results still awaited
    queue_cmd_t    cmd_backlog[$];
    queue_result_t result_backlog[$];

    // mirror of the queue contents, slot 0 is the head
    logic [TAG_BITS-1:0]      held_tag[DEPTH];
    logic [PRIORITY_BITS-1:0] held_prio[DEPTH];
    int                       held = 0;

    int  beats_sent = 0;
    int  results_checked = 0;
    int  failures = 0;
    int  cycles = 0;
    int  n_enq = 0;
    int  n_deq = 0;
    int  n_full = 0;
    int  n_empty = 0;
    int  peak_held = 0;
    bit  calm;

    sorted_insert_priority_queue_top #(
        .DEPTH         (DEPTH),
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .item_tag      (item_tag),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_tag       (out_tag),
        .out_priority  (out_priority),
        .entry_count   (entry_count)
    );

    always #5 clk = ~clk;

    // applies one command to the mirror and returns the result it should give
    function automatic queue_result_t sorted_queue_apply(
        logic cmd, logic [TAG_BITS-1:0] tag, logic [PRIORITY_BITS-1:0] prio);
        queue_result_t r;
        int            pos;
        r.status = siq_pkg::ST_DONE;
        r.tag    = '0;
        r.prio   = '0;
        if (cmd == siq_pkg::CMD_ENQUEUE)
        begin
            if (held == DEPTH)
            begin
                r.status = siq_pkg::ST_FULL;
                n_full++;
            end
            else
            begin
                // later arrivals go behind equal priorities
                pos = held;
                while (pos > 0 && prio < held_prio[pos-1])
                begin
                    held_tag[pos]  = held_tag[pos-1];
                    held_prio[pos] = held_prio[pos-1];
                    pos--;
                end
                held_tag[pos]  = tag;
                held_prio[pos] = prio;
                held++;
                n_enq++;
            end
        end
        else if (held == 0)
        begin
            r.status = siq_pkg::ST_EMPTY;
            n_empty++;
        end
        else
        begin
            r.tag  = held_tag[0];
            r.prio = held_prio[0];
            for (int k = 1; k < held; k++)
            begin
                held_tag[k-1]  = held_tag[k];
                held_prio[k-1] = held_prio[k];
            end
            held--;
            n_deq++;
        end
        if (held > peak_held)
            peak_held = held;
        r.count = held[CNT_W-1:0];
        return r;
    endfunction

    task automatic add_cmd(logic cmd, logic [TAG_BITS-1:0] tag,
                           logic [PRIORITY_BITS-1:0] prio, bit wait_drain);
        queue_cmd_t c;
        c.cmd        = cmd;
        c.tag        = tag;
        c.prio       = prio;
        c.wait_drain = wait_drain;
        cmd_backlog.push_back(c);
    endtask

    // no idling on either side for a stretch in the middle of the run
    assign calm = (beats_sent >= CALM_FIRST) && (beats_sent < CALM_LAST);

    // command driver
    always @(posedge clk)
    begin : drive
        bit drained;
        bit offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                beats_sent <= beats_sent + 1;
            if (!in_valid || !in_stall)
            begin
                offer = 1'b0;
                if (cmd_backlog.size() > 0)
                begin
                    drained = !(in_valid && !in_stall) && beats_sent == results_checked;
                    if (cmd_backlog[0].wait_drain && drained)
                        cmd_backlog[0].wait_drain = 1'b0;
                    if (!cmd_backlog[0].wait_drain)
                        offer = calm || ($urandom_range(99) >= IDLE_PCT);
                end
                if (offer)
                begin
                    in_valid      <= 1'b1;
                    command       <= cmd_backlog[0].cmd;
                    item_tag      <= cmd_backlog[0].tag;
                    item_priority <= cmd_backlog[0].prio;
                    void'(cmd_backlog.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // result checker, then prediction for the beat taken at this edge
    always @(posedge clk)
    begin : monitor
        queue_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_checked <= results_checked + 1;
                if (result_backlog.size() == 0)
                begin
                    $error("result beat with nothing awaited: status %0d tag %h",
                           status, out_tag);
                    failures++;
                end
                else
                begin
                    want = result_backlog.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        failures++;
                    end
                    if (out_tag !== want.tag)
                    begin
                        $error("out_tag: expected %h, got %h", want.tag, out_tag);
                        failures++;
                    end
                    if (out_priority !== want.prio)
                    begin
                        $error("out_priority: expected %0d, got %0d",
                               want.prio, out_priority);
                        failures++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.count, entry_count);
                        failures++;
                    end
                end
            end
            if (in_valid && !in_stall)
                result_backlog.push_back(
                    sorted_queue_apply(command, item_tag, item_priority));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int  left;
        int  burst;
        int  enq_pct;
        int  prio_top;
        bit  filling;

        // directed: empty dequeue, extreme tags, all priorities, ties, drain
        add_cmd(siq_pkg::CMD_DEQUEUE, 16'hFFFF, 2'd3, 1'b0);
        add_cmd(siq_pkg::CMD_ENQUEUE, 16'hFFFF, 2'd3, 1'b0);
        add_cmd(siq_pkg::CMD_ENQUEUE, 16'h0000, 2'd0, 1'b0);
        add_cmd(siq_pkg::CMD_ENQUEUE, 16'h1234, 2'd2, 1'b0);
        add_cmd(siq_pkg::CMD_ENQUEUE, 16'hA5A5, 2'd2, 1'b0);
        add_cmd(siq_pkg::CMD_ENQUEUE, 16'h5A5A, 2'd1, 1'b0);
        add_cmd(siq_pkg::CMD_ENQUEUE, 16'h0F0F, 2'd3, 1'b0);
        add_cmd(siq_pkg::CMD_ENQUEUE, 16'hF0F0, 2'd0, 1'b0);
        for (int k = 0; k < 8; k++)
            add_cmd(siq_pkg::CMD_DEQUEUE, TAG_BITS'($urandom()),
                    PRIORITY_BITS'($urandom()), 1'b0);

        // random: alternating fill and drain bursts so full and empty both recur
        left    = RANDOM_CMDS;
        filling = 1'b1;
        while (left > 0)
        begin
            burst    = $urandom_range(20, 45);
            enq_pct  = filling ? 85 : 15;
            if ($urandom_range(3) == 0)
                enq_pct = 50;
            // narrow priority range now and then for plenty of ties
            prio_top = ($urandom_range(1) == 0) ? 3 : $urandom_range(1);
            for (int k = 0; k < burst && left > 0; k++)
            begin
                add_cmd(($urandom_range(99) < enq_pct) ? siq_pkg::CMD_ENQUEUE
                                                       : siq_pkg::CMD_DEQUEUE,
                        TAG_BITS'($urandom()),
                        PRIORITY_BITS'($urandom_range(prio_top)),
                        (left == RANDOM_CMDS) || (left == RANDOM_CMDS / 2 && k == 0));
                left--;
            end
            filling = !filling;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // let everything drain, then allow the pipeline to settle
        while (cmd_backlog.size() > 0 || in_valid || beats_sent != results_checked)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (result_backlog.size() != 0)
        begin
            $error("%0d results never arrived", result_backlog.size());
            failures++;
        end
        $display("%0d commands: %0d enqueued, %0d dequeued, %0d rejected full, %0d empty",
                 beats_sent, n_enq, n_deq, n_full, n_empty);
        $display("peak occupancy %0d of %0d, %0d field mismatches", peak_held, DEPTH,
                 failures);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/siq_pkg.sv
hw/rtl/siq_cell.sv
hw/rtl/sorted_insert_priority_queue_top.sv
test/sorted_insert_priority_queue_top_tb.sv
